>>> hdl/string_key_hash_table_core_defines.svh
`ifndef STRING_KEY_HASH_TABLE_CORE_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKHT_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SKHT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/skht_pkg.sv
`default_nettype none

package skht_pkg;

	localparam int SLOTS         = 256;
	localparam int MAX_KEY_CHARS = 8;
	localparam int PAYLOAD_BITS  = 32;

	localparam int CHAR_W   = 8;
	localparam int KEY_W    = 64;
	localparam int LEN_W    = 4;
	localparam int MODE_W   = 2;
	localparam int OUT_W    = 32;
	localparam int CFG_W    = 9;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int SIZE_W   = IDX_W + 1;
	localparam int CNT_W    = SIZE_W;
	localparam int CHIDX_W  = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
	localparam int MOD_STEP = 4;
	localparam int MOD_CYC  = KEY_W / MOD_STEP;
	localparam int MODC_W   = $clog2(MOD_CYC);

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(SLOTS);

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [LEN_W-1:0]        len;
		logic [PAYLOAD_BITS-1:0] payload;
		mark_t                   mark;
	} slot_entry_t;

endpackage

`default_nettype wire

>>> hdl/skht_if.sv
`default_nettype none

interface skht_req_if;
	import skht_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_W-1:0]    key_chars;
	logic [LEN_W-1:0]    key_length;
	logic [OUT_W-1:0]    payload_in;

	modport source (output valid, mode, key_chars, key_length, payload_in, input ready);
	modport sink   (input valid, mode, key_chars, key_length, payload_in, output ready);
endinterface

interface skht_rsp_if;
	import skht_pkg::*;

	logic             valid;
	logic             ready;
	logic             ok;
	logic [OUT_W-1:0] payload_out;

	modport source (output valid, ok, payload_out, input ready);
	modport sink   (input valid, ok, payload_out, output ready);
endinterface

`default_nettype wire

>>> hdl/string_key_hash_table_core.sv
// Open-addressing hash table of string keys (up to 8 characters) with a 32-bit
// record per slot. One request is handled at a time: req.ready is high only
// while the core is idle, and a finished result waits in an output register, so a
// new request may enter while the previous result is still pending. A request
// is hashed one character per cycle through a 64-bit multiply-by-33-and-add,
// its hash is reduced modulo the table size (four quotient bits per cycle), each
// probed slot is read from the single-port slot memory and then compared or
// written, and the result is posted before the core returns to idle to take the
// next request. Posting waits while the output register still holds a result
// that has not been taken. Requests with a bad mode or key length skip hashing
// and probing and finish with ok low. Slot marks come out of reset empty
// through per-slot valid flops, so no clearing pass is needed; the capacity
// register is written through the APB port at address 0, and the user must
// write it only while the core is idle; the core itself does not enforce this.
`default_nettype none
`include "string_key_hash_table_core_defines.svh"

module string_key_hash_table_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	skht_req_if.sink                        req,
	skht_rsp_if.source                      rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [skht_pkg::PADDR_W-1:0] paddr,
	input  wire logic [skht_pkg::PDATA_W-1:0] pwdata,
	output logic [skht_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import skht_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HASH   = 6'b000010,
		S_MOD    = 6'b000100,
		S_PROBE  = 6'b001000,
		S_CHECK  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CFG_W-1:0]        capacity_q;
	logic [SIZE_W-1:0]       size_q;
	logic [MODE_W-1:0]       mode_q;
	logic [KEY_W-1:0]        key_q;
	logic [LEN_W-1:0]        len_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [KEY_W-1:0]        h_q;
	logic [CHIDX_W-1:0]      char_q;
	logic [MODC_W-1:0]       modc_q;
	logic [IDX_W-1:0]        rem_q;
	logic [IDX_W-1:0]        home_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        count_q;
	logic                    first_q;
	logic                    res_ok_q;
	logic [OUT_W-1:0]        res_pout_q;
	logic                    out_valid_q;
	logic                    out_ok_q;
	logic [OUT_W-1:0]        out_pout_q;

	slot_entry_t             mem_q [SLOTS];
	logic [SLOTS-1:0]        valid_q;
	slot_entry_t             rd_entry_q;
	logic                    rd_valid_q;

	logic                    accept;
	logic                    bad_req;
	logic [KEY_W-1:0]        key_masked;
	logic [SIZE_W-1:0]       eff_size;
	logic [KEY_W-1:0]        h_next;
	logic [IDX_W-1:0]        rem_next;
	logic [IDX_W:0]          rem_t;
	mark_t                   mark_cur;
	logic                    key_match;
	logic [CNT_W-1:0]        cnt_next;
	logic [SIZE_W:0]         idx_sum;
	logic [IDX_W-1:0]        idx_next;
	logic                    probe_end;
	logic                    mem_we;
	slot_entry_t             mem_wdata;
	logic                    cfg_we;
	logic                    out_load;

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ?
		PDATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (capacity_q > CFG_W'(SLOTS)) begin
			eff_size = SIZE_W'(SLOTS);
		end else begin
			eff_size = SIZE_W'(capacity_q);
		end
	end

	// request decode
	assign accept  = (state_q == S_IDLE) && req.valid;
	assign req.ready = (state_q == S_IDLE);
	assign bad_req = (req.key_length == '0) ||
		(req.key_length > LEN_W'(MAX_KEY_CHARS)) ||
		!((req.mode == MODE_INSERT) || (req.mode == MODE_SEARCH) ||
		(req.mode == MODE_REMOVE));

	always_comb begin
		for (int b = 0; b < KEY_W / CHAR_W; b++) begin
			key_masked[b*CHAR_W +: CHAR_W] = (LEN_W'(b) < req.key_length) ?
				req.key_chars[b*CHAR_W +: CHAR_W] : '0;
		end
	end

	// hash step: h * 33 + c
	assign h_next = (h_q << 5) + h_q +
		KEY_W'(key_q[{char_q, 3'b000} +: CHAR_W]);

	// modulo step: four restoring bits
	always_comb begin
		rem_next = rem_q;
		rem_t    = '0;
		for (int j = 0; j < MOD_STEP; j++) begin
			rem_t = {rem_next, h_q[KEY_W-1-j]};
			if (rem_t >= size_q) begin
				rem_t = rem_t - size_q;
			end
			rem_next = rem_t[IDX_W-1:0];
		end
	end

	// probe step
	assign mark_cur  = rd_valid_q ? rd_entry_q.mark : MARK_EMPTY;
	assign key_match = (mark_cur == MARK_USED) && (rd_entry_q.len == len_q) &&
		(rd_entry_q.key == key_q);
	assign cnt_next  = count_q + CNT_W'(1);
	assign idx_sum   = (SIZE_W+1)'(idx_q) + (SIZE_W+1)'(cnt_next);
	assign idx_next  = (idx_sum >= (SIZE_W+1)'(size_q)) ?
		IDX_W'(idx_sum - (SIZE_W+1)'(size_q)) : idx_sum[IDX_W-1:0];
	assign probe_end = (cnt_next > size_q) || (idx_next == home_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rd_entry_q;
		if (state_q == S_CHECK) begin
			if (mode_q == MODE_INSERT) begin
				if (mark_cur != MARK_USED) begin
					mem_we            = 1'b1;
					mem_wdata.key     = key_q;
					mem_wdata.len     = len_q;
					mem_wdata.payload = payload_q;
					mem_wdata.mark    = MARK_USED;
				end
			end else if (mode_q == MODE_REMOVE) begin
				if (!(!first_q && mark_cur == MARK_EMPTY) && key_match) begin
					mem_we         = 1'b1;
					mem_wdata.mark = MARK_DELETED;
				end
			end
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[idx_q] <= mem_wdata;
		end
		rd_entry_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			rd_valid_q <= valid_q[idx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= bad_req ? S_FINISH : S_HASH;
					end
				end
				S_HASH: begin
					if (char_q == '0) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (modc_q == '0) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (mode_q == MODE_INSERT) begin
						if (mark_cur != MARK_USED || probe_end) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_PROBE;
						end
					end else begin
						if ((!first_q && mark_cur == MARK_EMPTY) || key_match ||
							probe_end) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q     <= req.mode;
					key_q      <= key_masked;
					len_q      <= req.key_length;
					payload_q  <= req.payload_in[PAYLOAD_BITS-1:0];
					size_q     <= eff_size;
					h_q        <= '0;
					char_q     <= CHIDX_W'(req.key_length - LEN_W'(1));
					res_ok_q   <= 1'b0;
					res_pout_q <= '0;
				end
			end
			S_HASH: begin
				h_q <= h_next;
				if (char_q == '0) begin
					modc_q <= MODC_W'(MOD_CYC - 1);
					rem_q  <= '0;
				end else begin
					char_q <= char_q - CHIDX_W'(1);
				end
			end
			S_MOD: begin
				h_q    <= h_q << MOD_STEP;
				rem_q  <= rem_next;
				modc_q <= modc_q - MODC_W'(1);
				if (modc_q == '0) begin
					home_q  <= rem_next;
					idx_q   <= rem_next;
					count_q <= '0;
					first_q <= 1'b1;
				end
			end
			S_PROBE: begin
			end
			S_CHECK: begin
				if (mode_q == MODE_INSERT) begin
					if (mark_cur != MARK_USED) begin
						res_ok_q <= 1'b1;
					end
				end else if (!(!first_q && mark_cur == MARK_EMPTY) && key_match) begin
					res_ok_q <= 1'b1;
					if (mode_q == MODE_SEARCH) begin
						res_pout_q <= OUT_W'(rd_entry_q.payload);
					end
				end
				idx_q   <= idx_next;
				count_q <= cnt_next;
				first_q <= 1'b0;
			end
			S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// result register
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q   <= res_ok_q;
			out_pout_q <= res_pout_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.payload_out = out_pout_q;

	`SKHT_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted request left core idle")
	`SKHT_ASSERT_IMPL(a_probe_in_range, state_q == S_PROBE, SIZE_W'(idx_q) < size_q, "probe index outside table")
	`SKHT_ASSERT_IMPL(a_count_bound, state_q == S_CHECK, count_q <= size_q, "probe count beyond table size")
	`SKHT_ASSERT_IMPL(a_miss_zero_payload, rsp.valid && !rsp.ok, rsp.payload_out == '0, "failed request carries payload")

endmodule

`default_nettype wire

>>> dv/string_key_hash_table_core_tb.sv
`timescale 1ns / 100ps

module string_key_hash_table_core_tb;
	import skht_pkg::*;

	localparam int HASH_MULT = 33;
	localparam int RESET_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_STALL = 600;
	localparam int KEY_POOL = 12;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 64;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(REG_CAPACITY) << 2;

	typedef struct packed {
		logic             ok;
		logic [OUT_W-1:0] payload;
	} answer_t;

	typedef struct packed {
		logic [KEY_W-1:0] chars;
		logic [LEN_W-1:0] len;
	} pool_key_t;

	class hash_table_shadow;
		logic [KEY_W-1:0] keys [SLOTS];
		logic [LEN_W-1:0] lens [SLOTS];
		logic [OUT_W-1:0] payloads [SLOTS];
		mark_t marks [SLOTS];
		logic [CFG_W-1:0] size_setting;
		answer_t pending [$];
		int unsigned faults;

		function new();
			foreach (marks[i]) marks[i] = MARK_EMPTY;
			size_setting = CAPACITY_RESET;
			faults = 0;
		endfunction

		function void set_size(logic [CFG_W-1:0] value);
			size_setting = value;
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] chars,
			logic [LEN_W-1:0] len, logic [OUT_W-1:0] payload);
			logic [KEY_W-1:0] key;
			logic [KEY_W-1:0] h;
			int unsigned size, home, idx, count;
			answer_t ans;
			ans = '0;
			if (len >= 1 && len <= MAX_KEY_CHARS &&
				(mode == MODE_INSERT || mode == MODE_SEARCH || mode == MODE_REMOVE)) begin
				key = chars & (~64'd0 >> (KEY_W - CHAR_W * int'(len)));
				size = size_setting;
				if (size < 1) size = 1;
				if (size > SLOTS) size = SLOTS;
				h = '0;
				for (int i = 0; i < int'(len); i++)
					h = h * 64'(HASH_MULT) + 64'(key[(int'(len) - 1 - i) * CHAR_W +: CHAR_W]);
				home = int'(h % 64'(size));
				idx = home;
				count = 0;
				if (mode == MODE_INSERT) begin
					do begin
						if (marks[idx] != MARK_USED) begin
							keys[idx] = key;
							lens[idx] = len;
							payloads[idx] = payload;
							marks[idx] = MARK_USED;
							ans.ok = 1'b1;
							break;
						end
						count++;
						idx = (idx + count) % size;
						if (count > size) break;
					end while (idx != home);
				end else begin
					do begin
						if (marks[idx] == MARK_USED && lens[idx] == len && keys[idx] == key) begin
							ans.ok = 1'b1;
							if (mode == MODE_SEARCH)
								ans.payload = payloads[idx];
							else
								marks[idx] = MARK_DELETED;
							break;
						end
						count++;
						idx = (idx + count) % size;
						if (count > size) break;
					end while (marks[idx] != MARK_EMPTY && idx != home);
				end
			end
			pending.push_back(ans);
		endfunction

		function void check_response(logic ok, logic [OUT_W-1:0] payload_out);
			answer_t want;
			if (pending.size() == 0) begin
				$error("response with no request outstanding: ok=%0d payload_out=%h",
					ok, payload_out);
				faults++;
				return;
			end
			want = pending.pop_front();
			if (ok !== want.ok) begin
				$error("ok: expected %0d, got %0d", want.ok, ok);
				faults++;
			end
			if (payload_out !== want.payload) begin
				$error("payload_out: expected %h, got %h", want.payload, payload_out);
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	skht_req_if request_bus();
	skht_rsp_if response_bus();

	hash_table_shadow table_shadow = new();
	bit random_running = 1'b0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;

	string_key_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(request_bus),
		.rsp(response_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && response_bus.valid && response_bus.ready)
			table_shadow.check_response(response_bus.ok, response_bus.payload_out);
	end

	always @(posedge clk) begin
		if (!arst_n || (request_bus.valid && request_bus.ready) ||
			(response_bus.valid && response_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no request or response accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned style, left, stall_wait;
		bit stall_done;
		style = 0;
		left = 0;
		stall_done = 1'b0;
		stall_wait = $urandom_range(50, 400);
		response_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (random_running && !stall_done) begin
				if (stall_wait == 0) begin
					stall_done = 1'b1;
					response_bus.ready <= 1'b0;
					repeat (LONG_STALL) @(posedge clk);
				end else begin
					stall_wait--;
				end
			end
			if (left == 0) begin
				style = $urandom_range(0, 2);
				left = $urandom_range(20, 150);
			end
			left--;
			case (style)
				0: response_bus.ready <= 1'b1;
				1: response_bus.ready <= 1'($urandom_range(0, 1));
				default: response_bus.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic pace_requests();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			request_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	endtask

	task automatic submit(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] chars,
		logic [LEN_W-1:0] len, logic [OUT_W-1:0] payload);
		request_bus.valid <= 1'b1;
		request_bus.mode <= mode;
		request_bus.key_chars <= chars;
		request_bus.key_length <= len;
		request_bus.payload_in <= payload;
		do @(posedge clk); while (!request_bus.ready);
		table_shadow.note_request(mode, chars, len, payload);
		pace_requests();
	endtask

	task automatic settle();
		request_bus.valid <= 1'b0;
		while (table_shadow.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		table_shadow.set_size(value);
	endtask

	initial begin
		int unsigned phase_sizes [8];
		pool_key_t key_pool [KEY_POOL];
		pool_key_t pick;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0] chars, mask;
		logic [LEN_W-1:0] len;
		logic [OUT_W-1:0] payload;
		int unsigned counted, roll;

		phase_sizes = '{2, 7, 0, 61, 511, 256, 13, 256};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		request_bus.valid = 1'b0;
		request_bus.mode = MODE_INSERT;
		request_bus.key_chars = '0;
		request_bus.key_length = '0;
		request_bus.payload_in = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		submit(MODE_INSERT, 64'h0, 4'd1, 32'h0);
		submit(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
		submit(MODE_SEARCH, 64'h0, 4'd1, 32'hFFFF_FFFF);
		submit(MODE_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
		submit(MODE_SEARCH, 64'h0, 4'd2, 32'h0);
		submit(MODE_INSERT, 64'hA5A5_A5A5_A561_6263, 4'd3, 32'h1234_5678);
		submit(MODE_SEARCH, 64'h5A5A_5A5A_5A61_6263, 4'd3, 32'h0);
		submit(MODE_INSERT, 64'h0000_0000_0061_6263, 4'd3, 32'h0000_0009);
		submit(MODE_REMOVE, 64'h0000_0000_0061_6263, 4'd3, 32'h0);
		submit(MODE_SEARCH, 64'hFFFF_FFFF_FF61_6263, 4'd3, 32'h0);
		submit(MODE_REMOVE, 64'h0000_0000_0061_6263, 4'd3, 32'h0);
		submit(MODE_REMOVE, 64'h0000_0000_0061_6263, 4'd3, 32'h0);
		submit(MODE_SEARCH, 64'h0000_0000_0061_6263, 4'd3, 32'h0);
		submit(MODE_UNUSED, 64'h0000_0000_0061_6263, 4'd3, 32'hFFFF_FFFF);
		submit(MODE_INSERT, 64'h0000_0000_0061_6263, 4'd0, 32'h1);
		submit(MODE_INSERT, 64'h0000_0000_0061_6263, 4'd9, 32'h1);
		submit(MODE_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h1);

		settle();
		write_capacity(CFG_W'(1));
		submit(MODE_INSERT, 64'h78, 4'd1, 32'hCAFE_0001);
		submit(MODE_INSERT, 64'h79, 4'd1, 32'hCAFE_0002);
		submit(MODE_SEARCH, 64'h79, 4'd1, 32'h0);
		submit(MODE_REMOVE, 64'h78, 4'd1, 32'h0);
		submit(MODE_INSERT, 64'h79, 4'd1, 32'hCAFE_0003);
		submit(MODE_SEARCH, 64'h79, 4'd1, 32'h0);
		submit(MODE_SEARCH, 64'h78, 4'd1, 32'h0);

		random_running = 1'b1;
		foreach (phase_sizes[p]) begin
			settle();
			write_capacity(CFG_W'(phase_sizes[p]));
			for (int k = 0; k < KEY_POOL; k++) begin
				key_pool[k].len = LEN_W'($urandom_range(1, MAX_KEY_CHARS));
				key_pool[k].chars = {$urandom(), $urandom()} &
					(~64'd0 >> (KEY_W - CHAR_W * int'(key_pool[k].len)));
			end
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				payload = $urandom();
				chars = {$urandom(), $urandom()};
				if (roll < 5) begin
					if ($urandom_range(0, 1)) begin
						mode = MODE_UNUSED;
						len = LEN_W'($urandom_range(1, MAX_KEY_CHARS));
					end else begin
						mode = MODE_W'($urandom_range(0, 3));
						len = $urandom_range(0, 1) ? LEN_W'(0) :
							LEN_W'($urandom_range(MAX_KEY_CHARS + 1, 15));
					end
				end else begin
					mode = (roll < 40) ? MODE_INSERT : (roll < 75) ? MODE_SEARCH : MODE_REMOVE;
					if ($urandom_range(0, 4) != 0) begin
						pick = key_pool[$urandom_range(0, KEY_POOL - 1)];
						len = pick.len;
						mask = ~64'd0 >> (KEY_W - CHAR_W * int'(len));
						chars = (chars & ~mask) | pick.chars;
					end else begin
						len = LEN_W'($urandom_range(1, MAX_KEY_CHARS));
					end
					counted++;
				end
				submit(mode, chars, len, payload);
			end
		end

		request_bus.valid <= 1'b0;
		while (table_shadow.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (table_shadow.pending.size() != 0) begin
			$error("%0d responses never arrived", table_shadow.pending.size());
			table_shadow.faults++;
		end
		if (table_shadow.faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/skht_pkg.sv
hdl/skht_if.sv
hdl/string_key_hash_table_core.sv
dv/string_key_hash_table_core_tb.sv
